// File: src/vnorm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnorm_pkg
// Shared widths and stage records for the 3D vector normalizer.
// ---------------------------------------------------------------------------
package vnorm_pkg;

   localparam int COMP_BITS  = 16;
   localparam int UNIT_FRAC  = 14;
   localparam int UNIT_BITS  = UNIT_FRAC + 2;
   localparam int LEN_BITS   = COMP_BITS;
   localparam int SUM_BITS   = 2 * COMP_BITS;
   localparam int QUO_BITS   = UNIT_FRAC + 1;
   localparam int DIVD_BITS  = COMP_BITS + UNIT_FRAC;
   localparam int SQ_STAGES  = LEN_BITS;
   localparam int DV_STAGES  = QUO_BITS;
   localparam int FRONT_LAT  = 3;
   localparam int QDEPTH     = 8;
   localparam int QPTR_BITS  = $clog2(QDEPTH);

   typedef struct packed {
      logic [SUM_BITS-1:0]           sum;
      logic [2:0][COMP_BITS-1:0]     mag;
      logic [2:0]                    neg;
   } vnorm_item_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]           rem;
      logic [LEN_BITS-1:0]           root;
      logic [2:0][COMP_BITS-1:0]     mag;
      logic [2:0]                    neg;
   } vnorm_sq_type;

   typedef struct packed {
      logic [2:0][DIVD_BITS-1:0]     rem;
      logic [2:0][QUO_BITS-1:0]      quo;
      logic [LEN_BITS-1:0]           len;
      logic [2:0]                    neg;
   } vnorm_dv_type;

   typedef struct packed {
      logic push;
      logic full;
   } vnorm_qctl_type;

endpackage

// File: src/vnorm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnorm_front
// Takes vectors, splits sign and magnitude, squares and sums the components.
// ---------------------------------------------------------------------------
module vnorm_front
   import vnorm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic signed [COMP_BITS-1:0] comp_x,
   input  logic signed [COMP_BITS-1:0] comp_y,
   input  logic signed [COMP_BITS-1:0] comp_z,
   output logic                        push,
   output vnorm_item_type              item
);

   logic [2:0][COMP_BITS-1:0] in_vec;
   logic [2:0][COMP_BITS-1:0] mag_a_ff, mag_a_in, mag_b_ff;
   logic [2:0]                neg_a_ff, neg_a_in, neg_b_ff;
   logic [2:0][SUM_BITS-1:0]  sq_b_ff, sq_b_in;
   logic                      vld_a_ff, vld_b_ff, vld_c_ff;
   vnorm_item_type            item_c_ff, item_c_in;

   assign in_vec = {comp_z, comp_y, comp_x};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg_a_in[k] = in_vec[k][COMP_BITS-1];
         mag_a_in[k] = neg_a_in[k] ? COMP_BITS'(-in_vec[k]) : in_vec[k];
         sq_b_in[k]  = SUM_BITS'(mag_a_ff[k]) * SUM_BITS'(mag_a_ff[k]);
      end
      item_c_in.sum = sq_b_ff[0] + sq_b_ff[1] + sq_b_ff[2];
      item_c_in.mag = mag_b_ff;
      item_c_in.neg = neg_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else begin
         vld_a_ff <= take;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
      end
      mag_a_ff  <= mag_a_in;
      neg_a_ff  <= neg_a_in;
      sq_b_ff   <= sq_b_in;
      mag_b_ff  <= mag_a_ff;
      neg_b_ff  <= neg_a_ff;
      item_c_ff <= item_c_in;
   end

   assign push = vld_c_ff;
   assign item = item_c_ff;

endmodule

// File: src/vnorm_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnorm_queue
// Short queue between the front and back halves.
// ---------------------------------------------------------------------------
module vnorm_queue
   import vnorm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  vnorm_item_type wr_item,
   input  logic           pop,
   output logic           nonempty,
   output logic           near_full,
   output vnorm_item_type rd_item
);

   vnorm_item_type         slot_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_pop;

   assign do_pop   = pop && (count_ff != '0);
   assign count_in = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= wr_item;
   end

   assign nonempty  = (count_ff != '0);
   assign near_full = (count_ff > (QPTR_BITS+1)'(QDEPTH - FRONT_LAT - 1));
   assign rd_item   = slot_ff[rd_ptr_ff];

endmodule

// File: src/vnorm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnorm_back
// Bit-per-stage square root, then three bit-per-stage dividers.
// ---------------------------------------------------------------------------
module vnorm_back
   import vnorm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  vnorm_item_type              in_item,
   output logic                        out_valid,
   output logic [LEN_BITS-1:0]         out_length,
   output logic signed [UNIT_BITS-1:0] out_x,
   output logic signed [UNIT_BITS-1:0] out_y,
   output logic signed [UNIT_BITS-1:0] out_z,
   output logic                        out_zero
);

   function automatic vnorm_sq_type sq_step(vnorm_sq_type s, int b);
      vnorm_sq_type        r;
      logic [SUM_BITS:0]   t;
      r = s;
      t = ((SUM_BITS+1)'(s.root) << (b + 1)) + ((SUM_BITS+1)'(1) << (2 * b));
      if ({1'b0, s.rem} >= t) begin
         r.rem     = s.rem - t[SUM_BITS-1:0];
         r.root[b] = 1'b1;
      end
      return r;
   endfunction

   function automatic vnorm_dv_type dv_step(vnorm_dv_type s, int b);
      vnorm_dv_type         r;
      logic [DIVD_BITS:0]   t;
      r = s;
      t = (DIVD_BITS+1)'(s.len) << b;
      for (int k = 0; k < 3; k++) begin
         if ({1'b0, s.rem[k]} >= t) begin
            r.rem[k]    = s.rem[k] - t[DIVD_BITS-1:0];
            r.quo[k][b] = 1'b1;
         end
      end
      return r;
   endfunction

   vnorm_sq_type               sq_ff [SQ_STAGES];
   vnorm_sq_type               sq_in [SQ_STAGES];
   vnorm_dv_type               dv_ff [DV_STAGES];
   vnorm_dv_type               dv_in [DV_STAGES];
   logic [SQ_STAGES-1:0]       sq_vld_ff;
   logic [DV_STAGES-1:0]       dv_vld_ff;
   vnorm_sq_type               sq_head;
   vnorm_dv_type               dv_head;
   logic [2:0][UNIT_BITS-1:0]  unit_in, unit_ff;
   logic                       zero_in, zero_ff, out_vld_ff;
   logic [LEN_BITS-1:0]        len_ff;

   always_comb begin
      sq_head.rem  = in_item.sum;
      sq_head.root = '0;
      sq_head.mag  = in_item.mag;
      sq_head.neg  = in_item.neg;
      sq_in[0] = sq_step(sq_head, SQ_STAGES - 1);
      for (int i = 1; i < SQ_STAGES; i++) begin
         sq_in[i] = sq_step(sq_ff[i-1], SQ_STAGES - 1 - i);
      end

      for (int k = 0; k < 3; k++) begin
         dv_head.rem[k] = {sq_ff[SQ_STAGES-1].mag[k], {UNIT_FRAC{1'b0}}};
      end
      dv_head.quo = '0;
      dv_head.len = sq_ff[SQ_STAGES-1].root;
      dv_head.neg = sq_ff[SQ_STAGES-1].neg;
      dv_in[0] = dv_step(dv_head, DV_STAGES - 1);
      for (int j = 1; j < DV_STAGES; j++) begin
         dv_in[j] = dv_step(dv_ff[j-1], DV_STAGES - 1 - j);
      end

      zero_in = (dv_ff[DV_STAGES-1].len == '0);
      for (int k = 0; k < 3; k++) begin
         if (zero_in) begin
            unit_in[k] = '0;
         end else if (dv_ff[DV_STAGES-1].neg[k]) begin
            unit_in[k] = UNIT_BITS'(-{1'b0, dv_ff[DV_STAGES-1].quo[k]});
         end else begin
            unit_in[k] = UNIT_BITS'({1'b0, dv_ff[DV_STAGES-1].quo[k]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= '0;
         dv_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff  <= {sq_vld_ff[SQ_STAGES-2:0], in_valid};
         dv_vld_ff  <= {dv_vld_ff[DV_STAGES-2:0], sq_vld_ff[SQ_STAGES-1]};
         out_vld_ff <= dv_vld_ff[DV_STAGES-1];
      end
      for (int i = 0; i < SQ_STAGES; i++) sq_ff[i] <= sq_in[i];
      for (int j = 0; j < DV_STAGES; j++) dv_ff[j] <= dv_in[j];
      unit_ff <= unit_in;
      zero_ff <= zero_in;
      len_ff  <= dv_ff[DV_STAGES-1].len;
   end

   assign out_valid  = out_vld_ff;
   assign out_length = len_ff;
   assign out_x      = unit_ff[0];
   assign out_y      = unit_ff[1];
   assign out_z      = unit_ff[2];
   assign out_zero   = zero_ff;

endmodule

// File: src/vector3_normalize_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector3_normalize_top
// Length and unit direction of one Q8.8 vector per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   Drive req_comp_x/y/z and raise req_start; the transfer happens at an edge
//   where req_start is high and busy is low. One vector may be taken every
//   cycle while busy is low. Each vector yields exactly one result, shown
//   for one cycle with rsp_strobe high: rsp_vec_length (Q8.8), rsp_unit_x/y/z
//   (Q2.14, truncated toward zero) and rsp_zero_vector, which marks a zero
//   vector with zero unit components.
//   From the transfer edge to the result, a vector passes 3 front stages,
//   the queue, 16 square-root stages (one root bit each), 15 divider stages
//   (one quotient bit each) and the output register. Throughput is one
//   vector per cycle while busy is low; the queue between front and back
//   keeps busy low in steady streaming.
//   Reset clears all valid bits and the queue; no result is shown until a
//   new transfer has run through. The receiver cannot stall the results.
// ---------------------------------------------------------------------------
module vector3_normalize_top
   import vnorm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_start,
   output logic                        busy,
   input  logic signed [COMP_BITS-1:0] req_comp_x,
   input  logic signed [COMP_BITS-1:0] req_comp_y,
   input  logic signed [COMP_BITS-1:0] req_comp_z,
   output logic                        rsp_strobe,
   output logic [LEN_BITS-1:0]         rsp_vec_length,
   output logic signed [UNIT_BITS-1:0] rsp_unit_x,
   output logic signed [UNIT_BITS-1:0] rsp_unit_y,
   output logic signed [UNIT_BITS-1:0] rsp_unit_z,
   output logic                        rsp_zero_vector
);

   vnorm_qctl_type qctl;
   vnorm_item_type front_item, head_item;
   logic           head_valid;

   assign busy = qctl.full;

   vnorm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .take   (req_start && !busy),
      .comp_x (req_comp_x),
      .comp_y (req_comp_y),
      .comp_z (req_comp_z),
      .push   (qctl.push),
      .item   (front_item)
   );

   vnorm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (qctl.push),
      .wr_item   (front_item),
      .pop       (1'b1),
      .nonempty  (head_valid),
      .near_full (qctl.full),
      .rd_item   (head_item)
   );

   vnorm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (head_valid),
      .in_item    (head_item),
      .out_valid  (rsp_strobe),
      .out_length (rsp_vec_length),
      .out_x      (rsp_unit_x),
      .out_y      (rsp_unit_y),
      .out_z      (rsp_unit_z),
      .out_zero   (rsp_zero_vector)
   );

endmodule

// File: src/vnorm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnorm_checker
// Port-level checks on the normalizer results.
// ---------------------------------------------------------------------------
module vnorm_checker
   import vnorm_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [LEN_BITS-1:0]         rsp_vec_length,
   input logic signed [UNIT_BITS-1:0] rsp_unit_x,
   input logic signed [UNIT_BITS-1:0] rsp_unit_y,
   input logic signed [UNIT_BITS-1:0] rsp_unit_z,
   input logic                        rsp_zero_vector
);

   localparam logic signed [UNIT_BITS-1:0] UNIT_ONE = UNIT_BITS'(1) << UNIT_FRAC;

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_zero_vector |->
         rsp_vec_length == '0 && rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0)
      else $error("zero vector result has nonzero fields");

   a_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_zero_vector |-> rsp_vec_length != '0)
      else $error("nonzero result with zero length");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_unit_x <= UNIT_ONE && rsp_unit_x >= -UNIT_ONE
                  && rsp_unit_y <= UNIT_ONE && rsp_unit_y >= -UNIT_ONE
                  && rsp_unit_z <= UNIT_ONE && rsp_unit_z >= -UNIT_ONE)
      else $error("unit component out of range");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_strobe)
      else $error("strobe right after reset");

   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised while streaming");

endmodule

bind vector3_normalize_top vnorm_checker u_vnorm_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_vec_length  (rsp_vec_length),
   .rsp_unit_x      (rsp_unit_x),
   .rsp_unit_y      (rsp_unit_y),
   .rsp_unit_z      (rsp_unit_z),
   .rsp_zero_vector (rsp_zero_vector)
);
